// ===== src/sem_pkg.sv =====
package sem_pkg;

  localparam int PIX_W   = 8;
  localparam int ROW_W   = 16;
  localparam int CFGW_W  = 11;
  localparam int CFGD_W  = 16;
  localparam int GRAD_W  = 11;
  localparam int SQ_W    = 20;
  localparam int ROOT_W  = 16;
  localparam int ROOT_STEPS = 8;
  localparam logic [PIX_W-1:0] MAG_SAT = 8'd255;
  localparam logic [ROOT_W-1:0] ROOT_BIT_INIT = 16'h4000;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PX_RD,
    ST_PX_UPD,
    ST_DR_RD0,
    ST_DR_RD1,
    ST_DR_RD2,
    ST_DR_RD3,
    ST_MUL,
    ST_SUM,
    ST_ROOT,
    ST_OUT
  } sem_state_t;

  typedef enum logic [1:0] {
    ADDR_X,
    ADDR_LEFT,
    ADDR_MID,
    ADDR_RIGHT
  } addr_sel_t;

  typedef struct packed {
    logic      accept;
    addr_sel_t addr_sel;
    logic      px_update;
    logic      cap_en;
    logic [1:0] cap_col;
    logic      drain_finish;
    logic      mul;
    logic      sum;
    logic      root;
    logic      edge_sel;
  } sem_cmd_t;

  typedef struct packed {
    logic row_full;
    logic emit_inner;
    logic emit_edge;
    logic drain_last;
    logic root_done;
  } sem_status_t;

endpackage

// ===== src/sem_ctrl.sv =====
module sem_ctrl
  import sem_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        run_last,
  output logic        frame_end,
  input  sem_status_t st,
  output sem_cmd_t    cmd
);

  sem_state_t state, state_next;
  logic pend_edge, pend_edge_next;
  logic cur_edge, cur_edge_next;
  logic fend, fend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend_edge <= 1'b0;
      cur_edge  <= 1'b0;
      fend      <= 1'b0;
    end else begin
      state     <= state_next;
      pend_edge <= pend_edge_next;
      cur_edge  <= cur_edge_next;
      fend      <= fend_next;
    end
  end

  always_comb begin
    state_next     = state;
    pend_edge_next = pend_edge;
    cur_edge_next  = cur_edge;
    fend_next      = fend;
    cmd            = '0;
    cmd.addr_sel   = ADDR_X;
    cmd.edge_sel   = cur_edge;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (action == ACT_PIXEL) begin
            if (!st.row_full) state_next = ST_PX_RD;
          end else begin
            if (st.row_full) state_next = ST_DR_RD0;
          end
        end
      end
      ST_PX_RD: begin
        cmd.addr_sel = ADDR_X;
        state_next   = ST_PX_UPD;
      end
      ST_PX_UPD: begin
        cmd.addr_sel   = ADDR_X;
        cmd.px_update  = 1'b1;
        fend_next      = 1'b0;
        pend_edge_next = st.emit_inner && st.emit_edge;
        cur_edge_next  = !st.emit_inner;
        if (st.emit_inner || st.emit_edge) state_next = ST_MUL;
        else state_next = ST_IDLE;
      end
      ST_DR_RD0: begin
        cmd.addr_sel = ADDR_LEFT;
        state_next   = ST_DR_RD1;
      end
      ST_DR_RD1: begin
        cmd.addr_sel = ADDR_MID;
        cmd.cap_en   = 1'b1;
        cmd.cap_col  = 2'd0;
        state_next   = ST_DR_RD2;
      end
      ST_DR_RD2: begin
        cmd.addr_sel = ADDR_RIGHT;
        cmd.cap_en   = 1'b1;
        cmd.cap_col  = 2'd1;
        state_next   = ST_DR_RD3;
      end
      ST_DR_RD3: begin
        cmd.cap_en       = 1'b1;
        cmd.cap_col      = 2'd2;
        cmd.drain_finish = 1'b1;
        fend_next        = st.drain_last;
        pend_edge_next   = 1'b0;
        cur_edge_next    = 1'b0;
        state_next       = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root = 1'b1;
        if (st.root_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (pend_edge) begin
            pend_edge_next = 1'b0;
            cur_edge_next  = 1'b1;
            state_next     = ST_MUL;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign run_last  = !pend_edge;
  assign frame_end = fend;

endmodule

// ===== src/sem_datapath.sv =====
module sem_datapath
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [0:0]        cfg_index,
  input  logic [CFGD_W-1:0] cfg_data,
  input  logic [PIX_W-1:0]  pixel,
  input  sem_cmd_t          cmd,
  output sem_status_t       st,
  output logic [PIX_W-1:0]  magnitude
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;

  logic [CFGW_W-1:0] image_width;
  logic [ROW_W-1:0]  image_height;
  logic [CW-1:0]     w_eff;
  logic [ROW_W-1:0]  h_eff;

  logic [AW-1:0]    colc, drc;
  logic [ROW_W-1:0] rowc;
  logic [PIX_W-1:0] px_r;

  logic [PIX_W-1:0] mem_up [MAX_WIDTH];
  logic [PIX_W-1:0] mem_lo [MAX_WIDTH];
  logic [PIX_W-1:0] rd_up, rd_lo;
  logic [AW-1:0]    addr;
  logic [AW-1:0]    left_idx, right_idx;

  logic [PIX_W-1:0] win [3][3];
  logic [PIX_W-1:0] col [3];
  logic [PIX_W-1:0] dcol [3];

  logic [CW-1:0] x_ext, x_inc, d_ext, d_inc, w_m1;

  logic signed [GRAD_W-1:0] gx, gy;
  logic [PIX_W-1:0] lc [3];
  logic [PIX_W-1:0] cc [3];
  logic [PIX_W-1:0] rc [3];
  logic [SQ_W-1:0]  sqx, sqy;
  logic [SQ_W:0]    sum;

  logic [ROOT_W-1:0] rv, rres, rbit;
  logic [ROOT_W:0]   rtry;
  logic [2:0]        rcnt;
  logic              rsat;

  always_comb begin
    if (image_width == '0) w_eff = CW'(1);
    else if (32'(image_width) > 32'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(image_width);
    h_eff = (image_height == '0) ? ROW_W'(1) : image_height;
  end

  assign x_ext = {1'b0, colc};
  assign x_inc = x_ext + CW'(1);
  assign d_ext = {1'b0, drc};
  assign d_inc = d_ext + CW'(1);
  assign w_m1  = w_eff - CW'(1);

  assign st.row_full   = rowc >= h_eff;
  assign st.emit_inner = (rowc != '0) && (colc != '0);
  assign st.emit_edge  = (rowc != '0) && (x_ext == w_m1);
  assign st.drain_last = d_ext == w_m1;
  assign st.root_done  = rcnt == 3'(ROOT_STEPS - 1);

  assign left_idx  = (drc == '0) ? '0 : drc - AW'(1);
  assign right_idx = (d_inc < w_eff) ? d_inc[AW-1:0] : w_m1[AW-1:0];

  always_comb begin
    case (cmd.addr_sel)
      ADDR_LEFT:  addr = left_idx;
      ADDR_MID:   addr = drc;
      ADDR_RIGHT: addr = right_idx;
      default:    addr = colc;
    endcase
  end

  // line stores; upper takes the old lower row, lower takes the new pixel
  always_ff @(posedge clk) begin
    if (cmd.px_update) begin
      mem_up[addr] <= rd_lo;
      mem_lo[addr] <= px_r;
    end
    rd_up <= mem_up[addr];
    rd_lo <= mem_lo[addr];
  end

  always_comb begin
    col[0]  = (rowc >= ROW_W'(2)) ? rd_up : rd_lo;
    col[1]  = rd_lo;
    col[2]  = px_r;
    dcol[0] = (h_eff >= ROW_W'(2)) ? rd_up : rd_lo;
    dcol[1] = rd_lo;
    dcol[2] = rd_lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFGW_W'(1024);
      image_height <= ROW_W'(768);
      colc <= '0;
      rowc <= '0;
      drc  <= '0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) win[c][r] <= '0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_WIDTH:  image_width  <= cfg_data[CFGW_W-1:0];
          REG_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
        colc <= '0;
        rowc <= '0;
        drc  <= '0;
      end
      if (cmd.px_update) begin
        for (int r = 0; r < 3; r++) begin
          if (colc == '0) begin
            win[0][r] <= col[r];
            win[1][r] <= col[r];
            win[2][r] <= col[r];
          end else begin
            win[0][r] <= win[1][r];
            win[1][r] <= win[2][r];
            win[2][r] <= col[r];
          end
        end
        if (x_inc >= w_eff) begin
          colc <= '0;
          rowc <= rowc + ROW_W'(1);
        end else begin
          colc <= x_inc[AW-1:0];
        end
      end
      if (cmd.cap_en) begin
        for (int r = 0; r < 3; r++) win[cmd.cap_col][r] <= dcol[r];
      end
      if (cmd.drain_finish) begin
        if (st.drain_last) begin
          drc  <= '0;
          rowc <= '0;
          colc <= '0;
        end else begin
          drc <= d_inc[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) px_r <= pixel;
  end

  // right-edge result reuses the last column as its own right neighbor
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lc[r] = cmd.edge_sel ? win[1][r] : win[0][r];
      cc[r] = cmd.edge_sel ? win[2][r] : win[1][r];
      rc[r] = win[2][r];
    end
    gx = (GRAD_W'(rc[0]) + (GRAD_W'(rc[1]) <<< 1) + GRAD_W'(rc[2]))
       - (GRAD_W'(lc[0]) + (GRAD_W'(lc[1]) <<< 1) + GRAD_W'(lc[2]));
    gy = (GRAD_W'(lc[2]) + (GRAD_W'(cc[2]) <<< 1) + GRAD_W'(rc[2]))
       - (GRAD_W'(lc[0]) + (GRAD_W'(cc[0]) <<< 1) + GRAD_W'(rc[0]));
  end

  logic signed [2*GRAD_W-1:0] px2, py2;
  assign px2 = gx * gx;
  assign py2 = gy * gy;
  assign sum = {1'b0, sqx} + {1'b0, sqy};
  assign rtry = {1'b0, rres} + {1'b0, rbit};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      sqx <= px2[SQ_W-1:0];
      sqy <= py2[SQ_W-1:0];
    end
    if (cmd.sum) begin
      rv   <= sum[ROOT_W-1:0];
      rsat <= |sum[SQ_W:ROOT_W];
      rres <= '0;
      rbit <= ROOT_BIT_INIT;
      rcnt <= '0;
    end else if (cmd.root) begin
      if ({1'b0, rv} >= rtry) begin
        rv   <= rv - rtry[ROOT_W-1:0];
        rres <= (rres >> 1) + rbit;
      end else begin
        rres <= rres >> 1;
      end
      rbit <= rbit >> 2;
      rcnt <= rcnt + 3'd1;
    end
  end

  assign magnitude = rsat ? MAG_SAT : rres[PIX_W-1:0];

endmodule

// ===== src/sobel_edge_magnitude_top.sv =====
// 3x3 Sobel edge magnitude over a raster stream of 8-bit grey pixels, with
// replicated borders. Results trail the input by one row: the pixel at (x,y)
// yields the result for (x-1,y-1), and the last pixel of a row also yields
// (w-1,y-1); the first row yields nothing. Once a frame's pixels are all in,
// drain transactions (action = 1) return the last row, one result each,
// with frame_end on the final one; pixel transactions are dropped until the
// drain completes, and a drain sent early is dropped. run_last marks the
// last result of each input transaction. Magnitude is floor(sqrt(gx^2+gy^2))
// clipped to 255. Writing image_width (index 0) or image_height (index 1)
// restarts the frame; write only while the block is idle. One transaction
// is handled at a time, and each result is held until out_ready. Per
// result, gx and gy are squared into registers, then summed, then go
// through the bit-serial square root. Line stores have one read port
// each, so a drain reads its three columns in turn. The line stores are
// not cleared at reset.
module sobel_edge_magnitude_top
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [0:0]        cfg_index,
  input  logic [CFGD_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              action,
  input  logic [PIX_W-1:0]  pixel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  magnitude,
  output logic              run_last,
  output logic              frame_end
);

  sem_cmd_t    cmd;
  sem_status_t st;

  // sequencer: handshakes, read order of the line stores, result count
  sem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .run_last  (run_last),
    .frame_end (frame_end),
    .st        (st),
    .cmd       (cmd)
  );

  // line stores, window, counters, squares and root
  sem_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pixel),
    .cmd       (cmd),
    .st        (st),
    .magnitude (magnitude)
  );

`ifndef SYNTH
  // one transaction at a time: no new input while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

  // frame end only on the last result of a transaction
  a_fend_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> run_last)
    else $error("frame_end without run_last");

  // pixel update never runs once the frame is full
  a_px_inframe: assert property (@(posedge clk) disable iff (rst)
    cmd.px_update |-> !st.row_full)
    else $error("pixel written past frame end");

  // a result is followed by idle or the edge result, never a read
  a_after_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> (!out_valid && !cmd.px_update))
    else $error("bad sequence after result");
`endif

endmodule
